/* src/scrb_pkg.sv */
package scrb_pkg;

   // Field and bus widths.
   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int CELL_W      = 20;
   localparam int COUNT_W     = 23;
   localparam int CFG_W       = 11;
   localparam int SIZE_W      = 17;
   localparam int NUM_WORDS   = 5;
   localparam int REQ_W       = 224;
   localparam int RSP_W       = 80;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   // Default grid limits.
   localparam int DEF_MAX_ROW_CELLS = 1024;
   localparam int DEF_MAX_ROWS      = 1024;

   // Register reset values and the smallest usable grid dimension.
   localparam logic [CFG_W-1:0]  CELLS_RESET = 11'd16;
   localparam logic [CFG_W-1:0]  ROWS_RESET  = 11'd16;
   localparam logic [SIZE_W-1:0] MIN_SIZE    = 17'd2;

   // Register indexes.
   localparam logic REG_CELLS_PER_ROW = 1'b0;
   localparam logic REG_ROWS_IN_GRID  = 1'b1;

   // Saturation limits of a signed Q16.16 value.
   localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

   // Slots of the word array in a queued command. Boundary cells reuse the
   // first two slots for the boundary coefficient and the temperature.
   localparam int W_WEST    = 0;
   localparam int W_NORTH   = 1;
   localparam int W_CENTRE  = 2;
   localparam int W_EAST    = 3;
   localparam int W_SOUTH   = 4;
   localparam int W_BOUND_F = 0;
   localparam int W_BOUND_T = 1;

   typedef logic [DATA_W-1:0] word_type;

   typedef struct packed {
      logic                            is_boundary;
      logic                            grid_end;
      logic [CELL_W-1:0]               cell_idx;
      logic [CELL_W-1:0]               ncol;
      logic [NUM_WORDS-1:0][DATA_W-1:0] words;
   } cmd_type;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      logic     fault;
      word_type value;
   } div_rsp_type;

endpackage

/* src/scrb_queue.sv */
module scrb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scrb_pkg::cmd_type push_cmd,
   input  logic              pop,
   output scrb_pkg::cmd_type head_cmd,
   output logic              full,
   output logic              empty
);
   import scrb_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

   cmd_type           slot_ff [QUEUE_DEPTH];
   cmd_type           slot_in [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full     = fill_ff == FULL_FILL;
   assign empty    = fill_ff == '0;
   assign head_cmd = slot_ff[rd_ff];

   always_comb begin
      slot_in = slot_ff;
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         slot_in[wr_ff] = push_cmd;
         wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* src/scrb_front.sv */
module scrb_front #(
   parameter int MAX_ROW_CELLS = scrb_pkg::DEF_MAX_ROW_CELLS,
   parameter int MAX_ROWS      = scrb_pkg::DEF_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [scrb_pkg::REQ_W-1:0]    req_tdata,
   input  logic [scrb_pkg::CFG_W-1:0]    cells_per_row,
   input  logic [scrb_pkg::CFG_W-1:0]    rows_in_grid,
   input  logic                          queue_full,
   output logic                          push,
   output scrb_pkg::cmd_type             push_cmd
);
   import scrb_pkg::*;

   localparam int COL_W = $clog2(MAX_ROW_CELLS);
   localparam int ROW_W = $clog2(MAX_ROWS);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CELL_W-1:0] cell_ff, cell_in;

   logic [SIZE_W-1:0] ncol, nrow;
   logic              last_col, last_row, boundary;
   word_type          in_word [7];

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] wide;
      logic [SIZE_W-1:0] res;
      wide = SIZE_W'(v);
      if (wide < MIN_SIZE) begin
         res = MIN_SIZE;
      end else if (wide > hi) begin
         res = hi;
      end else begin
         res = wide;
      end
      return res;
   endfunction

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         in_word[i] = req_tdata[i*DATA_W +: DATA_W];
      end
   end

   assign ncol     = clamp_size(cells_per_row, SIZE_W'(MAX_ROW_CELLS));
   assign nrow     = clamp_size(rows_in_grid, SIZE_W'(MAX_ROWS));
   // A position at or past the end counts as the end, so a size change in
   // the middle of a grid still closes the row or the grid.
   assign last_col = SIZE_W'(col_ff) >= (ncol - SIZE_W'(1));
   assign last_row = SIZE_W'(row_ff) >= (nrow - SIZE_W'(1));
   assign boundary = (col_ff == '0) || (row_ff == '0) || last_col || last_row;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_cmd.is_boundary      = boundary;
      push_cmd.grid_end         = last_col && last_row;
      push_cmd.cell_idx         = cell_ff;
      push_cmd.ncol             = CELL_W'(ncol);
      push_cmd.words[W_WEST]    = boundary ? in_word[5] : in_word[0];
      push_cmd.words[W_NORTH]   = boundary ? in_word[6] : in_word[1];
      push_cmd.words[W_CENTRE]  = in_word[2];
      push_cmd.words[W_EAST]    = in_word[3];
      push_cmd.words[W_SOUTH]   = in_word[4];
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      cell_in = cell_ff;
      if (push) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               cell_in = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               cell_in = cell_ff + 1'b1;
            end
         end else begin
            col_in  = col_ff + 1'b1;
            cell_in = cell_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cell_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cell_ff <= cell_in;
      end
   end

endmodule

/* src/scrb_divider.sv */
module scrb_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  scrb_pkg::div_req_type div_req,
   output scrb_pkg::div_rsp_type div_rsp
);
   import scrb_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   word_type          rem_ff, rem_in;
   word_type          num_ff, num_in;
   word_type          tmag_ff, tmag_in;
   word_type          quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;
   logic              fault_ff, fault_in;
   word_type          value_ff, value_in;

   word_type          fmag, tmag;
   logic              f_pos, neg_start, too_big;
   logic [DATA_W+1:0] diff;

   // Magnitudes of the operands; the dividend is F shifted up by the
   // fraction width, with its sign flipped.
   assign fmag      = div_req.dividend[DATA_W-1] ? ('0 - div_req.dividend) : div_req.dividend;
   assign tmag      = div_req.divisor[DATA_W-1] ? ('0 - div_req.divisor) : div_req.divisor;
   assign f_pos     = !div_req.dividend[DATA_W-1] && (div_req.dividend != '0);
   assign neg_start = f_pos != div_req.divisor[DATA_W-1];
   // The quotient needs more than 32 bits, or the divisor is zero.
   assign too_big   = DATA_W'(fmag[DATA_W-1:FRAC_W]) >= tmag;
   assign diff      = {1'b0, rem_ff, num_ff[DATA_W-1]} - {2'b00, tmag_ff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      tmag_in  = tmag_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      fault_in = fault_ff;
      value_in = value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (div_req.start) begin
               neg_in = neg_start;
               if (too_big) begin
                  done_in  = 1'b1;
                  fault_in = 1'b1;
                  if (div_req.dividend == '0) begin
                     value_in = '0;
                  end else begin
                     value_in = neg_start ? Q_MIN : Q_MAX;
                  end
               end else begin
                  tmag_in  = tmag;
                  rem_in   = DATA_W'(fmag[DATA_W-1:FRAC_W]);
                  num_in   = {fmag[FRAC_W-1:0], {FRAC_W{1'b0}}};
                  quo_in   = '0;
                  step_in  = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // One restoring step: bring in the next dividend bit and try
            // subtracting the divisor.
            if (!diff[DATA_W+1]) begin
               rem_in = diff[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DATA_W-2:0], num_ff[DATA_W-1]};
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            num_in  = {num_ff[DATA_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            done_in  = 1'b1;
            state_in = ST_IDLE;
            if (neg_ff) begin
               if (quo_ff > Q_MIN) begin
                  fault_in = 1'b1;
                  value_in = Q_MIN;
               end else begin
                  fault_in = 1'b0;
                  value_in = '0 - quo_ff;
               end
            end else begin
               if (quo_ff[DATA_W-1]) begin
                  fault_in = 1'b1;
                  value_in = Q_MAX;
               end else begin
                  fault_in = 1'b0;
                  value_in = quo_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      tmag_ff  <= tmag_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      fault_ff <= fault_in;
      value_ff <= value_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.fault = fault_ff;
   assign div_rsp.value = value_ff;

endmodule

/* src/scrb_back.sv */
module scrb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  scrb_pkg::cmd_type             head_cmd,
   input  logic                          queue_empty,
   output logic                          pop,
   output scrb_pkg::div_req_type         div_req,
   input  scrb_pkg::div_rsp_type         div_rsp,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [scrb_pkg::DATA_W-1:0]   rsp_value,
   output logic [scrb_pkg::CELL_W-1:0]   rsp_column,
   output logic [scrb_pkg::COUNT_W-1:0]  rsp_count,
   output logic                          rsp_last,
   output logic                          rsp_fault
);
   import scrb_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [2:0] STEP_NORTH  = 3'd0;
   localparam logic [2:0] STEP_WEST   = 3'd1;
   localparam logic [2:0] STEP_CENTRE = 3'd2;
   localparam logic [2:0] STEP_EAST   = 3'd3;
   localparam logic [2:0] STEP_SOUTH  = 3'd4;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   cmd_type            cur_ff, cur_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   word_type           dval_ff, dval_in;
   logic               dfault_ff, dfault_in;
   logic               oval_ff, oval_in;
   word_type           ovalue_ff, ovalue_in;
   logic [CELL_W-1:0]  ocol_ff, ocol_in;
   logic [COUNT_W-1:0] ocount_ff, ocount_in;
   logic               olast_ff, olast_in;
   logic               ofault_ff, ofault_in;

   logic               out_free;
   word_type           sel_value;
   logic [CELL_W-1:0]  sel_col;
   logic               sel_last, sel_fault;
   logic [COUNT_W-1:0] count_next;

   assign out_free   = !oval_ff || rsp_tready;
   assign count_next = count_ff + 1'b1;

   assign div_req.dividend = head_cmd.words[W_BOUND_F];
   assign div_req.divisor  = head_cmd.words[W_BOUND_T];
   assign div_req.start    = (state_ff == ST_IDLE) && !queue_empty && head_cmd.is_boundary;
   assign pop              = (state_ff == ST_IDLE) && !queue_empty;

   // Entry picked for the current output step.
   always_comb begin
      sel_value = dval_ff;
      sel_col   = cur_ff.cell_idx;
      sel_last  = 1'b1;
      sel_fault = dfault_ff;
      if (!cur_ff.is_boundary) begin
         sel_fault = 1'b0;
         sel_last  = 1'b0;
         case (step_ff)
            STEP_NORTH: begin
               sel_value = cur_ff.words[W_NORTH];
               sel_col   = cur_ff.cell_idx - cur_ff.ncol;
            end
            STEP_WEST: begin
               sel_value = cur_ff.words[W_WEST];
               sel_col   = cur_ff.cell_idx - 1'b1;
            end
            STEP_CENTRE: begin
               sel_value = cur_ff.words[W_CENTRE];
               sel_col   = cur_ff.cell_idx;
            end
            STEP_EAST: begin
               sel_value = cur_ff.words[W_EAST];
               sel_col   = cur_ff.cell_idx + 1'b1;
            end
            default: begin
               sel_value = cur_ff.words[W_SOUTH];
               sel_col   = cur_ff.cell_idx + cur_ff.ncol;
               sel_last  = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      dval_in   = dval_ff;
      dfault_in = dfault_ff;
      oval_in   = oval_ff && !rsp_tready;
      ovalue_in = ovalue_ff;
      ocol_in   = ocol_ff;
      ocount_in = ocount_ff;
      olast_in  = olast_ff;
      ofault_in = ofault_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               cur_in   = head_cmd;
               step_in  = STEP_NORTH;
               state_in = head_cmd.is_boundary ? ST_DIV : ST_EMIT;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               dval_in   = div_rsp.value;
               dfault_in = div_rsp.fault;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               oval_in   = 1'b1;
               ovalue_in = sel_value;
               ocol_in   = sel_col;
               ocount_in = count_next;
               olast_in  = sel_last;
               ofault_in = sel_fault;
               if (sel_last) begin
                  // The counter restarts once the last cell of the grid is out.
                  count_in = cur_ff.grid_end ? '0 : count_next;
                  state_in = ST_IDLE;
               end else begin
                  count_in = count_next;
                  step_in  = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      cur_ff    <= cur_in;
      dval_ff   <= dval_in;
      dfault_ff <= dfault_in;
      ovalue_ff <= ovalue_in;
      ocol_ff   <= ocol_in;
      ocount_ff <= ocount_in;
      olast_ff  <= olast_in;
      ofault_ff <= ofault_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         oval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         oval_ff  <= oval_in;
      end
   end

   assign rsp_tvalid = oval_ff;
   assign rsp_value  = ovalue_ff;
   assign rsp_column = ocol_ff;
   assign rsp_count  = ocount_ff;
   assign rsp_last   = olast_ff;
   assign rsp_fault  = ofault_ff;

endmodule

/* src/stencil_csr_row_builder.sv */
// Five-point stencil CSR row builder. Grid cells arrive one item each in
// row-major order, and the block emits the sparse-matrix entries of each
// cell's row in CSR order. A cell on the outer rim of the grid yields one
// diagonal entry, -F/T in signed Q16.16, saturated, with divide_fault set on
// saturation or a zero temperature. An interior cell yields five entries,
// north, west, centre, east and south, with their column indices. Every entry
// carries the running entry count, so a cell's last entry holds the row end
// pointer; the count and the cell position restart after the last cell of
// the grid. A front stage accepts an item whenever the queue has room,
// classifies it and tags it with its cell number, and parks it in a
// two-entry queue; a back stage works one cell at a time. An interior cell
// is dequeued and then gives five entries, one entry per cycle while the
// output register is free. For a boundary cell the back stage waits on the
// divider, which sets up, produces one quotient bit per cycle for all 32
// bits and then rounds to range; when the quotient clearly overflows or the
// temperature is zero, it skips the bit steps. Results leave through an
// output register, so the block keeps working while a finished entry waits
// to be taken. The grid size is set by two registers, cells_per_row at byte
// address 0 and rows_in_grid at byte address 4, each clamped to 2 up to the
// size limits; write them only while the block is idle.
module stencil_csr_row_builder #(
   parameter int MAX_ROW_CELLS = scrb_pkg::DEF_MAX_ROW_CELLS,
   parameter int MAX_ROWS      = scrb_pkg::DEF_MAX_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input items.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: coef_west, coef_north, coef_centre, coef_east,
   // coef_south, coef_boundary, temperature, each 32 bits.
   input  logic [scrb_pkg::REQ_W-1:0]        req_tdata,
   // Result items.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0 up: entry_value (32), column_index (20),
   // entry_count (23), then five zero bits.
   output logic [scrb_pkg::RSP_W-1:0]        rsp_tdata,
   // Marks the last entry of a cell (last_of_cell).
   output logic                              rsp_tlast,
   // Fields: divide_fault.
   output logic                              rsp_tuser,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [scrb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [scrb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [scrb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import scrb_pkg::*;

   logic [CFG_W-1:0]   cells_ff, cells_in;
   logic [CFG_W-1:0]   rows_ff, rows_in;
   logic               csr_write;
   logic               csr_index;

   logic               push, pop, queue_full, queue_empty;
   cmd_type            push_cmd, head_cmd;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   word_type           rsp_value;
   logic [CELL_W-1:0]  rsp_column;
   logic [COUNT_W-1:0] rsp_count;

   // The register index is the word address; the port never waits.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cells_in = cells_ff;
      rows_in  = rows_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CELLS_PER_ROW: cells_in = csr_pwdata[CFG_W-1:0];
            REG_ROWS_IN_GRID:  rows_in  = csr_pwdata[CFG_W-1:0];
            default:           cells_in = cells_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CELLS_PER_ROW: csr_prdata = CSR_DATA_W'(cells_ff);
         REG_ROWS_IN_GRID:  csr_prdata = CSR_DATA_W'(rows_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= CELLS_RESET;
         rows_ff  <= ROWS_RESET;
      end else begin
         cells_ff <= cells_in;
         rows_ff  <= rows_in;
      end
   end

   scrb_front #(
      .MAX_ROW_CELLS (MAX_ROW_CELLS),
      .MAX_ROWS      (MAX_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .cells_per_row (cells_ff),
      .rows_in_grid  (rows_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   scrb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   scrb_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   scrb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_column  (rsp_column),
      .rsp_count   (rsp_count),
      .rsp_last    (rsp_tlast),
      .rsp_fault   (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_W - DATA_W - CELL_W - COUNT_W){1'b0}},
                       rsp_count, rsp_column, rsp_value};

endmodule

/* tb/tb_stencil_csr_row_builder.sv */
`timescale 1ns / 100ps

module tb_stencil_csr_row_builder;
   import scrb_pkg::*;

   // Cells sent after the directed table, and the cycle budget of the whole run.
   // A boundary cell holds the block while the divider runs, and each of up to five
   // entries per cell may wait on a stalled receiver, so the budget is many times
   // the slowest correct run.
   localparam int RANDOM_CELLS = 460;
   localparam int CYCLE_LIMIT  = 600000;

   // One grid cell as it travels on req_tdata.
   typedef struct packed {
      logic [DATA_W-1:0] west;
      logic [DATA_W-1:0] north;
      logic [DATA_W-1:0] centre;
      logic [DATA_W-1:0] east;
      logic [DATA_W-1:0] south;
      logic [DATA_W-1:0] bound;
      logic [DATA_W-1:0] temp;
   } cell_item_t;

   // One sparse-matrix entry as it travels on the result channel.
   typedef struct packed {
      logic [DATA_W-1:0]  value;
      logic [CELL_W-1:0]  column;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               fault;
   } matrix_entry_t;

   // A row of the directed table. When known is set, the value and fault flag
   // of the boundary entry are typed in here rather than computed.
   typedef struct packed {
      cell_item_t        site;
      logic              known;
      logic [DATA_W-1:0] value;
      logic              fault;
   } directed_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // When set, neither side inserts idle cycles.
   logic steady = 1'b0;

   // Entries the grid walk says must still come out, oldest first.
   matrix_entry_t pending_entries[$];
   directed_row_t directed_rows[$];
   int            mismatches = 0;
   int            cycle_count = 0;

   // Our own copy of the grid configuration and walk position.
   logic [CFG_W-1:0]   grid_cells_cfg = CELLS_RESET;
   logic [CFG_W-1:0]   grid_rows_cfg  = ROWS_RESET;
   int unsigned        walk_col = 0;
   int unsigned        walk_row = 0;
   logic [CELL_W-1:0]  walk_cell = '0;
   logic [COUNT_W-1:0] entry_total = '0;

   stencil_csr_row_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Watchdog. A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL stencil_csr_row_builder");
         $finish;
      end
   end

   // The receiver stalls about 30 percent of the time, except in the steady stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 30);
      end
   end

   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void push_entry(input logic [DATA_W-1:0] value,
                                      input logic [CELL_W-1:0] column,
                                      input logic last, input logic fault);
      matrix_entry_t e;
      entry_total = entry_total + 1'b1;
      e.value  = value;
      e.column = column;
      e.count  = entry_total;
      e.last   = last;
      e.fault  = fault;
      pending_entries.push_back(e);
   endfunction

   // Works out the entries of one accepted cell and advances the grid walk.
   // A position at or past the last column or row (after the size shrank)
   // counts as the last one.
   function automatic void predict_cell(input cell_item_t c, input logic known,
                                        input logic [DATA_W-1:0] known_value,
                                        input logic known_fault);
      int unsigned       ncol;
      int unsigned       nrow;
      logic              last_col;
      logic              last_row;
      logic [CELL_W-1:0] span;
      longint            f;
      longint            t;
      longint            q;
      logic [DATA_W-1:0] value;
      logic              fault;
      ncol = clamp_size(grid_cells_cfg, DEF_MAX_ROW_CELLS);
      nrow = clamp_size(grid_rows_cfg, DEF_MAX_ROWS);
      span = CELL_W'(ncol);
      last_col = walk_col >= ncol - 1;
      last_row = walk_row >= nrow - 1;
      if (walk_col == 0 || walk_row == 0 || last_col || last_row) begin
         // Boundary cell: one diagonal entry, -F / T in Q16.16.
         f = longint'($signed(c.bound));
         t = longint'($signed(c.temp));
         fault = 1'b0;
         if (t == 0) begin
            // Zero temperature saturates toward the sign of -F.
            fault = 1'b1;
            if (f > 0) value = Q_MIN;
            else if (f < 0) value = Q_MAX;
            else value = '0;
         end else begin
            q = (-f * 64'sd65536) / t;
            if (q > 64'sd2147483647) begin
               value = Q_MAX;
               fault = 1'b1;
            end else if (q < -64'sd2147483648) begin
               value = Q_MIN;
               fault = 1'b1;
            end else begin
               value = DATA_W'(q);
            end
         end
         if (known) begin
            value = known_value;
            fault = known_fault;
         end
         push_entry(value, walk_cell, 1'b1, fault);
      end else begin
         push_entry(c.north, walk_cell - span, 1'b0, 1'b0);
         push_entry(c.west, walk_cell - 1'b1, 1'b0, 1'b0);
         push_entry(c.centre, walk_cell, 1'b0, 1'b0);
         push_entry(c.east, walk_cell + 1'b1, 1'b0, 1'b0);
         push_entry(c.south, walk_cell + span, 1'b1, 1'b0);
      end
      if (last_col && last_row) begin
         // End of the grid: everything starts over.
         walk_col = 0;
         walk_row = 0;
         walk_cell = '0;
         entry_total = '0;
      end else begin
         if (last_col) begin
            walk_col = 0;
            walk_row++;
         end else begin
            walk_col++;
         end
         walk_cell = walk_cell + 1'b1;
      end
   endfunction

   // Checks every accepted entry against the oldest one still pending.
   always @(posedge clock) begin
      matrix_entry_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_entries.size() == 0) begin
            $error("unexpected entry: got %0h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_entries.pop_front();
            check_field("entry_value", want.value, rsp_tdata[31:0]);
            check_field("column_index", want.column, rsp_tdata[51:32]);
            check_field("entry_count", want.count, rsp_tdata[74:52]);
            check_field("last_of_cell", want.last, rsp_tlast);
            check_field("divide_fault", want.fault, rsp_tuser);
         end
      end
   end

   task automatic add_row(input logic [31:0] west, north, centre, east, south,
                          input logic [31:0] bound, temp,
                          input logic known, input logic [31:0] value, input logic fault);
      directed_row_t r;
      r.site  = '{west, north, centre, east, south, bound, temp};
      r.known = known;
      r.value = value;
      r.fault = fault;
      directed_rows.push_back(r);
   endtask

   // Sends one cell, idling first at random, and records its entries once taken.
   // Only one assignment to req_tvalid happens in any time step.
   task automatic send_cell(input directed_row_t r);
      while (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {r.site.temp, r.site.bound, r.site.south, r.site.east,
                    r.site.centre, r.site.north, r.site.west};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_cell(r.site, r.known, r.value, r.fault);
   endtask

   // Holds the sender off until every pending entry has come out.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_entries.size() != 0) @(posedge clock);
   endtask

   // Register write followed by a read back of the same register. psel stays
   // high across the two transfers.
   task automatic write_reg(input logic index, input logic [CFG_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      addr = CSR_ADDR_W'(4 * int'(index));
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      // Bits above the register width are junk that must be dropped.
      csr_pwdata  <= {21'($urandom_range(2097151)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (index == REG_CELLS_PER_ROW) grid_cells_cfg = value;
      else grid_rows_cfg = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field("csr readback", CSR_DATA_W'(value), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly small grids so that rows and whole grids close often, with the
   // out-of-range and largest values now and then.
   function automatic logic [CFG_W-1:0] pick_size();
      case ($urandom_range(11))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 1024;
         4: return 1025;
         5: return 2047;
         6, 7, 8: return CFG_W'($urandom_range(3, 6));
         default: return CFG_W'($urandom_range(2, 40));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return '0;
         3: return '1;
         4, 5: return DATA_W'($urandom_range(32'h10_0000) - 32'h8_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic directed_row_t random_row();
      directed_row_t r;
      r.site.west   = pick_word();
      r.site.north  = pick_word();
      r.site.centre = pick_word();
      r.site.east   = pick_word();
      r.site.south  = pick_word();
      r.site.bound  = pick_word();
      r.site.temp   = ($urandom_range(7) == 0) ? '0 : pick_word();
      r.known = 1'b0;
      r.value = '0;
      r.fault = 1'b0;
      return r;
   endfunction

   initial begin
      int               phase;
      int               sent;
      int               burst;
      logic [CFG_W-1:0] cells;
      logic [CFG_W-1:0] rows;

      // Directed table, run on the reset grid of 16 by 16. The first row is all
      // rim, so it carries the division cases; the second row reaches interior
      // cells with extreme coefficients.
      add_row(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 1, 32'hFFFF_0000, 0);
      // Zero temperature with positive, negative and zero F.
      add_row(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_0000, 1, Q_MIN, 1);
      add_row(0, 0, 0, 0, 0, 32'hFFFF_0000, 32'h0000_0000, 1, Q_MAX, 1);
      add_row(0, 0, 0, 0, 0, 32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 1);
      // Quotients far outside the range saturate; equal operands, a negative temperature and a zero F do not.
      add_row(0, 0, 0, 0, 0, Q_MAX, 32'h0000_0001, 1, Q_MIN, 1);
      add_row(0, 0, 0, 0, 0, Q_MIN, 32'h0000_0001, 1, Q_MAX, 1);
      add_row(0, 0, 0, 0, 0, Q_MIN, Q_MIN, 1, 32'hFFFF_0000, 0);
      add_row(0, 0, 0, 0, 0, Q_MAX, Q_MAX, 1, 32'hFFFF_0000, 0);
      add_row(0, 0, 0, 0, 0, 32'h0000_8000, 32'hFFFF_0000, 1, 32'h0000_8000, 0);
      add_row(0, 0, 0, 0, 0, 32'h0000_0000, 32'h1234_5678, 1, 32'h0000_0000, 0);
      // Truncation toward zero of a negative quotient.
      add_row(0, 0, 0, 0, 0, 32'h0000_0001, 32'h0000_0003, 1, 32'hFFFF_AAAB, 0);
      // Just inside, just past and exactly at the edges of the range.
      add_row(0, 0, 0, 0, 0, 32'h7FFF_0000, 32'h0001_0000, 1, 32'h8001_0000, 0);
      add_row(0, 0, 0, 0, 0, Q_MIN, 32'h0001_0000, 1, Q_MAX, 1);
      add_row(0, 0, 0, 0, 0, Q_MIN, 32'hFFFF_0000, 1, Q_MIN, 0);
      add_row(0, 0, 0, 0, 0, 32'h1234_5678, 32'h00AB_CDEF, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 0, 0, 0);
      // Second row: rim cell, then two interior cells.
      add_row(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 1, 32'hFFFF_8000, 0);
      add_row(Q_MIN, Q_MAX, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
              32'h0001_0000, 32'h0000_0000, 0, 0, 0);
      add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, Q_MAX, Q_MIN,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_cell(directed_rows[i]);

      // Random phases. Registers change only once the block has drained, which
      // usually leaves the walk in the middle of a grid, so a shrinking size
      // lands the position past the new last column or row.
      phase = 0;
      sent = 0;
      while (sent < RANDOM_CELLS) begin
         wait_drained();
         steady <= (phase == 5);
         case (phase)
            0: begin cells = 2;    rows = 2;    end
            1: begin cells = 3;    rows = 3;    end
            2: begin cells = 0;    rows = 2047; end
            3: begin cells = 2047; rows = 1;    end
            4: begin cells = 4;    rows = 1025; end
            default: begin
               cells = pick_size();
               rows = pick_size();
            end
         endcase
         // Later phases sometimes change only one of the two sizes.
         if (phase < 5 || $urandom_range(3) != 0) write_reg(REG_CELLS_PER_ROW, cells);
         if (phase < 5 || $urandom_range(3) != 0) write_reg(REG_ROWS_IN_GRID, rows);
         if (phase == 5) burst = 60;
         else if (clamp_size(grid_cells_cfg, DEF_MAX_ROW_CELLS) > 64 ||
                  clamp_size(grid_rows_cfg, DEF_MAX_ROWS) > 64) burst = $urandom_range(6, 16);
         else burst = $urandom_range(15, 45);
         for (int n = 0; n < burst && sent < RANDOM_CELLS; n++) begin
            send_cell(random_row());
            sent++;
            // Now and then the sender waits for the block to empty out.
            if ($urandom_range(39) == 0) wait_drained();
         end
         phase++;
      end

      steady <= 1'b0;
      wait_drained();
      // Leave room for any stray entry to show up.
      repeat (80) @(posedge clock);
      if (mismatches == 0 && pending_entries.size() == 0) begin
         $display("PASS stencil_csr_row_builder");
      end else begin
         $display("FAIL stencil_csr_row_builder");
      end
      $finish;
   end

endmodule

/* sim.f */
src/scrb_pkg.sv
src/scrb_queue.sv
src/scrb_front.sv
src/scrb_divider.sv
src/scrb_back.sv
src/stencil_csr_row_builder.sv
tb/tb_stencil_csr_row_builder.sv
